[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/efa_pkg.sv]
// ----------------------------------------------------------------------------
// efa_pkg
// types, constants and the byte-wide crc-32 fold for the fcs appender
// ----------------------------------------------------------------------------
package efa_pkg;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } efa_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_fcs;
        logic       frame_end;
    } efa_out_t;

    // request passed from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [31:0] fcs;
    } efa_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } efa_qstat_t;

    // reflected crc-32, eight bit steps
    function automatic logic [31:0] efa_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h00_0000, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[sv/efa_front.sv]
// ----------------------------------------------------------------------------
// efa_front
// accepts frame bytes, keeps the running crc, queues one request per byte
// ----------------------------------------------------------------------------
module efa_front import efa_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  efa_in_t    s_payload,
    input  efa_qstat_t q_status,
    output logic       push,
    output efa_req_t   push_req
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] crc_fold;

    assign s_ready  = !q_status.full;
    assign push     = s_valid && s_ready;
    assign crc_fold = efa_fold(crc_reg, s_payload.data_byte);

    assign push_req.data = s_payload.data_byte;
    assign push_req.last = s_payload.last_byte;
    assign push_req.fcs  = ~crc_fold;

    always_comb begin
        crc_next = crc_reg;
        if (push) begin
            crc_next = s_payload.last_byte ? CRC_INIT : crc_fold;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

endmodule

[sv/efa_queue.sv]
// ----------------------------------------------------------------------------
// efa_queue
// small register fifo between front and back
// ----------------------------------------------------------------------------
module efa_queue import efa_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  efa_req_t   push_req,
    input  logic       pop,
    output efa_req_t   head,
    output efa_qstat_t q_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    efa_req_t       store_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign head           = store_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CW'(DEPTH));
    assign q_status.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/efa_back.sv]
// ----------------------------------------------------------------------------
// efa_back
// emits each queued byte and, after a last byte, the four fcs bytes
// ----------------------------------------------------------------------------
module efa_back import efa_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  efa_qstat_t q_status,
    input  efa_req_t   head,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output efa_out_t   m_payload
);

    localparam logic [2:0] PH_DATA = 3'd0;
    localparam logic [2:0] PH_FCS0 = 3'd1;
    localparam logic [2:0] PH_FCS1 = 3'd2;
    localparam logic [2:0] PH_FCS2 = 3'd3;
    localparam logic [2:0] PH_FCS3 = 3'd4;

    logic [2:0] phase_reg, phase_next;
    logic       valid_reg, valid_next;
    efa_out_t   out_reg, out_next;
    logic       load;

    assign load      = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_payload = out_reg;

    always_comb begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        pop        = 1'b0;
        if (load) begin
            unique case (phase_reg)
                PH_DATA: begin
                    valid_next = !q_status.empty;
                    out_next.out_byte  = head.data;
                    out_next.is_fcs    = 1'b0;
                    out_next.frame_end = 1'b0;
                    if (!q_status.empty) begin
                        if (head.last) begin
                            phase_next = PH_FCS0;
                        end else begin
                            pop = 1'b1;
                        end
                    end
                end
                PH_FCS0: begin
                    valid_next = 1'b1;
                    out_next   = '{out_byte: head.fcs[7:0], is_fcs: 1'b1, frame_end: 1'b0};
                    phase_next = PH_FCS1;
                end
                PH_FCS1: begin
                    valid_next = 1'b1;
                    out_next   = '{out_byte: head.fcs[15:8], is_fcs: 1'b1, frame_end: 1'b0};
                    phase_next = PH_FCS2;
                end
                PH_FCS2: begin
                    valid_next = 1'b1;
                    out_next   = '{out_byte: head.fcs[23:16], is_fcs: 1'b1, frame_end: 1'b0};
                    phase_next = PH_FCS3;
                end
                PH_FCS3: begin
                    valid_next = 1'b1;
                    out_next   = '{out_byte: head.fcs[31:24], is_fcs: 1'b1, frame_end: 1'b1};
                    phase_next = PH_DATA;
                    pop        = 1'b1;
                end
                default: begin
                    valid_next = 1'b0;
                    phase_next = PH_DATA;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DATA;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

endmodule

[sv/ethernet_fcs_appender_unit.sv]
// ----------------------------------------------------------------------------
// ethernet_fcs_appender_unit
// path: an accepted request is written to the queue, then registered at the output
// throughput: one byte per cycle while m_ready is high; a last byte is followed
//   by four fcs bytes; the queue (QUEUE_DEPTH entries) absorbs input meanwhile
// reset: synchronous aresetn clears crc to all ones, empties queue and output
// ----------------------------------------------------------------------------
module ethernet_fcs_appender_unit import efa_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  efa_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output efa_out_t m_payload
);

    efa_qstat_t q_status;
    efa_req_t   push_req;
    efa_req_t   head;
    logic       push;
    logic       pop;

    efa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_status  (q_status),
        .push      (push),
        .push_req  (push_req)
    );

    efa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    efa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

[sv/efa_checker.sv]
// ----------------------------------------------------------------------------
// efa_checker
// port-level checks on the fcs appender, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module efa_checker import efa_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input efa_in_t  s_payload,
    input logic     m_valid,
    input logic     m_ready,
    input efa_out_t m_payload
);

    logic m_take;
    assign m_take = m_valid && m_ready;

    `ASSERT_NXT(a_in_hold, aclk, aresetn, s_valid && !s_ready,
        s_valid && $stable(s_payload), "waiting request changed")
    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_payload), "stalled result changed")
    `ASSERT_IMP(a_end_is_fcs, aclk, aresetn, m_valid && m_payload.frame_end,
        m_payload.is_fcs, "frame end on a non-fcs byte")
    `ASSERT_NXT(a_fcs_run, aclk, aresetn, m_take && m_payload.is_fcs && !m_payload.frame_end,
        m_valid && m_payload.is_fcs, "fcs bytes not contiguous")
    `ASSERT_NXT(a_after_end, aclk, aresetn, m_take && m_payload.frame_end,
        !(m_valid && m_payload.is_fcs), "fcs byte after frame end")

endmodule

bind ethernet_fcs_appender_unit efa_checker u_efa_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
